FILE: rtl/core/plaw_pkg.sv
`timescale 1ns / 1ps
// Shared types, formats and command codes of the arc length locator.
package plaw_pkg;

    // Fixed-point formats. Coordinates are Q16.16; lengths and distances are Q32.16.
    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int LEN_W   = 33;
    localparam int RAD_W   = 66;
    localparam int PROD_W  = 65;
    localparam int DIST_W  = 48;
    localparam int ADV_W   = 47;

    // Remaining distance and running sum, sized for the largest stores the block supports.
    localparam int REM_W = 52;
    localparam int SUM_W = 51;

    // Step counts of the iterative units.
    localparam int SQRT_STEPS = 33;
    localparam int MUL_STEPS  = 33;
    localparam int DIV_STEPS  = 65;
    localparam int STEP_W     = 7;

    localparam logic [2:0] CMD_CLEAR      = 3'd0;
    localparam logic [2:0] CMD_PATH_POINT = 3'd1;
    localparam logic [2:0] CMD_LINK_START = 3'd2;
    localparam logic [2:0] CMD_LINK_POINT = 3'd3;
    localparam logic [2:0] CMD_QUERY      = 3'd4;

    localparam logic [1:0] ST_PATH = 2'd0;
    localparam logic [1:0] ST_LINK = 2'd1;
    localparam logic [1:0] ST_PAST = 2'd2;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_SQUARE,
        SQ_ROOT,
        SQ_DONE
    } t_sq_state;

    typedef enum logic [1:0] {
        LP_IDLE,
        LP_MUL,
        LP_DIV,
        LP_DONE
    } t_lp_state;

    typedef enum logic [4:0] {
        W_IDLE,
        W_BRK_FETCH,
        W_BRK_POS,
        W_BRK_END,
        W_DISPATCH,
        W_LINK_TOP,
        W_SEG_A,
        W_SEG_B,
        W_SEG_C,
        W_LEN_GO,
        W_LEN_WAIT,
        W_CHECK,
        W_LERP_GO,
        W_LERP_WAIT,
        W_LEND_RD,
        W_LEND_CAP,
        W_FINISH
    } t_walk_state;

    typedef struct packed {
        logic                      start;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [DIFF_W-1:0]  dz;
    } t_sqrt_req;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] len;
    } t_sqrt_rsp;

    typedef struct packed {
        logic                      start;
        logic signed [COORD_W-1:0] p0;
        logic signed [COORD_W-1:0] p1;
        logic [LEN_W-1:0]          num;
        logic [LEN_W-1:0]          den;
    } t_lerp_req;

    typedef struct packed {
        logic                      done;
        logic signed [COORD_W-1:0] point;
    } t_lerp_rsp;

    // Magnitude of a coordinate difference; it always fits 32 bits.
    function automatic logic [COORD_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] m;
        m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        return m[COORD_W-1:0];
    endfunction

endpackage

FILE: rtl/core/plaw_sqrt.sv
`timescale 1ns / 1ps
// Segment length unit: sum of three squares, then a bit-per-cycle integer square root.
module plaw_sqrt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  plaw_pkg::t_sqrt_req  i_req,
    output plaw_pkg::t_sqrt_rsp  o_rsp
);

    plaw_pkg::t_sq_state r_state, n_state;

    logic [plaw_pkg::COORD_W-1:0]   r_op0, r_op1, r_op2;
    logic [1:0]                     r_k;
    logic [2*plaw_pkg::COORD_W-1:0] r_prod;
    logic [plaw_pkg::RAD_W-1:0]     r_rad;
    logic [plaw_pkg::LEN_W+1:0]     r_rem;
    logic [plaw_pkg::LEN_W-1:0]     r_root;
    logic [plaw_pkg::STEP_W-1:0]    r_cnt;

    logic [plaw_pkg::COORD_W-1:0]   w_op;
    logic [plaw_pkg::LEN_W+3:0]     w_rem_sh;
    logic [plaw_pkg::LEN_W+1:0]     w_trial;
    logic [plaw_pkg::LEN_W+3:0]     w_diff;
    logic                           w_fit;

    always_comb begin
        case (r_k)
            2'd0:    w_op = r_op0;
            2'd1:    w_op = r_op1;
            default: w_op = r_op2;
        endcase
    end

    // One result bit per step: bring down two radicand bits, try root*4+1.
    assign w_rem_sh = {r_rem, r_rad[plaw_pkg::RAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_fit    = w_rem_sh >= (plaw_pkg::LEN_W+4)'(w_trial);
    assign w_diff   = w_rem_sh - (plaw_pkg::LEN_W+4)'(w_trial);

    always_comb begin
        n_state = r_state;
        case (r_state)
            plaw_pkg::SQ_IDLE:   if (i_req.start) n_state = plaw_pkg::SQ_SQUARE;
            plaw_pkg::SQ_SQUARE: if (r_k == 2'd3) n_state = plaw_pkg::SQ_ROOT;
            plaw_pkg::SQ_ROOT: begin
                if (r_cnt == plaw_pkg::STEP_W'(plaw_pkg::SQRT_STEPS - 1)) begin
                    n_state = plaw_pkg::SQ_DONE;
                end
            end
            plaw_pkg::SQ_DONE:   n_state = plaw_pkg::SQ_IDLE;
            default:             n_state = plaw_pkg::SQ_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done = (r_state == plaw_pkg::SQ_DONE);
        o_rsp.len  = r_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plaw_pkg::SQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            plaw_pkg::SQ_IDLE: begin
                r_op0  <= plaw_pkg::abs_diff(i_req.dx);
                r_op1  <= plaw_pkg::abs_diff(i_req.dy);
                r_op2  <= plaw_pkg::abs_diff(i_req.dz);
                r_k    <= 2'd0;
                r_rad  <= '0;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            plaw_pkg::SQ_SQUARE: begin
                // The product of one cycle is accumulated in the next.
                if (r_k != 2'd3) r_prod <= w_op * w_op;
                if (r_k != 2'd0) r_rad <= r_rad + plaw_pkg::RAD_W'(r_prod);
                r_k <= r_k + 2'd1;
            end
            plaw_pkg::SQ_ROOT: begin
                r_rad  <= {r_rad[plaw_pkg::RAD_W-3:0], 2'b00};
                r_rem  <= w_fit ? w_diff[plaw_pkg::LEN_W+1:0] : w_rem_sh[plaw_pkg::LEN_W+1:0];
                r_root <= {r_root[plaw_pkg::LEN_W-2:0], w_fit};
                r_cnt  <= r_cnt + plaw_pkg::STEP_W'(1);
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/plaw_lerp.sv
`timescale 1ns / 1ps
// Interpolation unit: p0 + (p1 - p0) * num / den with shift-add multiply and long division.
module plaw_lerp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  plaw_pkg::t_lerp_req  i_req,
    output plaw_pkg::t_lerp_rsp  o_rsp
);

    plaw_pkg::t_lp_state r_state, n_state;

    logic signed [plaw_pkg::COORD_W-1:0] r_p0;
    logic                                r_neg;
    logic [plaw_pkg::COORD_W-1:0]        r_ad;
    logic [plaw_pkg::LEN_W-1:0]          r_num;
    logic [plaw_pkg::LEN_W-1:0]          r_den;
    logic [plaw_pkg::PROD_W-1:0]         r_prod;
    logic [plaw_pkg::LEN_W-1:0]          r_rem;
    logic [plaw_pkg::STEP_W-1:0]         r_cnt;

    logic signed [plaw_pkg::DIFF_W-1:0]  w_d;
    logic [plaw_pkg::LEN_W:0]            w_t;
    logic [plaw_pkg::LEN_W:0]            w_tsub;
    logic                                w_fit;
    logic [plaw_pkg::DIFF_W-1:0]         w_sum;
    logic [plaw_pkg::DIFF_W-1:0]         w_q;

    assign w_d    = {i_req.p1[plaw_pkg::COORD_W-1], i_req.p1}
                  - {i_req.p0[plaw_pkg::COORD_W-1], i_req.p0};
    assign w_t    = {r_rem, r_prod[plaw_pkg::PROD_W-1]};
    assign w_fit  = w_t >= {1'b0, r_den};
    assign w_tsub = w_t - {1'b0, r_den};

    // The quotient never exceeds the difference magnitude, so it fits 32 bits.
    assign w_q   = {1'b0, r_prod[plaw_pkg::COORD_W-1:0]};
    assign w_sum = r_neg ? {r_p0[plaw_pkg::COORD_W-1], r_p0} - w_q
                         : {r_p0[plaw_pkg::COORD_W-1], r_p0} + w_q;

    always_comb begin
        n_state = r_state;
        case (r_state)
            plaw_pkg::LP_IDLE: if (i_req.start) n_state = plaw_pkg::LP_MUL;
            plaw_pkg::LP_MUL: begin
                if (r_cnt == plaw_pkg::STEP_W'(plaw_pkg::MUL_STEPS - 1)) begin
                    n_state = plaw_pkg::LP_DIV;
                end
            end
            plaw_pkg::LP_DIV: begin
                if (r_cnt == plaw_pkg::STEP_W'(plaw_pkg::DIV_STEPS - 1)) begin
                    n_state = plaw_pkg::LP_DONE;
                end
            end
            plaw_pkg::LP_DONE: n_state = plaw_pkg::LP_IDLE;
            default:           n_state = plaw_pkg::LP_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done  = (r_state == plaw_pkg::LP_DONE);
        o_rsp.point = (r_den == '0) ? r_p0 : w_sum[plaw_pkg::COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plaw_pkg::LP_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            plaw_pkg::LP_IDLE: begin
                r_p0   <= i_req.p0;
                r_neg  <= w_d[plaw_pkg::DIFF_W-1];
                r_ad   <= plaw_pkg::abs_diff(w_d);
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_prod <= '0;
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            plaw_pkg::LP_MUL: begin
                r_prod <= {r_prod[plaw_pkg::PROD_W-2:0], 1'b0}
                        + (r_num[plaw_pkg::LEN_W-1] ? plaw_pkg::PROD_W'(r_ad) : '0);
                r_num  <= {r_num[plaw_pkg::LEN_W-2:0], 1'b0};
                if (r_cnt == plaw_pkg::STEP_W'(plaw_pkg::MUL_STEPS - 1)) begin
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + plaw_pkg::STEP_W'(1);
                end
            end
            plaw_pkg::LP_DIV: begin
                // Quotient bits shift in from the bottom as dividend bits leave the top.
                r_rem  <= w_fit ? w_tsub[plaw_pkg::LEN_W-1:0] : w_t[plaw_pkg::LEN_W-1:0];
                r_prod <= {r_prod[plaw_pkg::PROD_W-2:0], w_fit};
                r_cnt  <= r_cnt + plaw_pkg::STEP_W'(1);
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/polyline_arc_length_locator.sv
`timescale 1ns / 1ps
// Toolpath arc length locator: point stores, break table and the walking sequencer.
//
// The block holds a 2D toolpath and 3D link polylines in on-chip memories and answers
// distance queries along the combined path. Load commands (clear, path point, link start,
// link point) are taken one per cycle while the block is idle, and produce no result. A query
// walks the stored segments one at a time. Each walked segment costs two point reads, three
// squares on a shared 32x32 multiplier and a 33-step square root. Each link adds its break
// table reads and the read of its closing point. On the segment where the walk stops, the
// point is interpolated per axis by a shift-add multiply and a 65-step long division, one
// axis after the other. The time a query takes thus depends on the segments walked, the
// links entered and whether the walk stops on a segment. One query is in flight at a time.
// The finished result sits in an output register, so the next command transfer is taken
// while the result still waits. The stores are not cleared after reset and need no
// clearing pass; they are only read below their fill counts.
module polyline_arc_length_locator #(
    parameter int PATH_DEPTH       = 1024,
    parameter int LINK_POINT_DEPTH = 1024,
    parameter int LINK_COUNT       = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic signed [47:0] i_distance,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z,
    output logic [10:0]        o_path_segment,
    output logic signed [7:0]  o_link_number,
    output logic [10:0]        o_link_segment,
    output logic [46:0]        o_advanced_length
);

    localparam int CW    = plaw_pkg::COORD_W;
    localparam int PA_W  = $clog2(PATH_DEPTH);
    localparam int PC_W  = $clog2(PATH_DEPTH + 1);
    localparam int LA_W  = $clog2(LINK_POINT_DEPTH);
    localparam int LC_W  = $clog2(LINK_POINT_DEPTH + 1);
    localparam int BA_W  = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;
    localparam int BC_W  = $clog2(LINK_COUNT + 1);
    localparam int BRK_W = PC_W + LC_W;

    plaw_pkg::t_walk_state r_state, n_state;

    // Point stores and break table. A break entry holds {path position, first link point}.
    logic [2*CW-1:0]  r_path_mem [PATH_DEPTH];
    logic [2*CW-1:0]  r_lxy_mem  [LINK_POINT_DEPTH];
    logic [CW-1:0]    r_lz_mem   [LINK_POINT_DEPTH];
    logic [BRK_W-1:0] r_brk_mem  [LINK_COUNT];
    logic [2*CW-1:0]  r_path_rd;
    logic [2*CW-1:0]  r_lxy_rd;
    logic [CW-1:0]    r_lz_rd;
    logic [BRK_W-1:0] r_brk_rd;

    logic [PC_W-1:0] r_pc;
    logic [LC_W-1:0] r_lpc;
    logic [BC_W-1:0] r_bc;

    // Walk state.
    logic [PC_W-1:0]                 r_i;
    logic [BC_W-1:0]                 r_j;
    logic                            r_bvalid;
    logic [PC_W-1:0]                 r_bpos;
    logic [LC_W-1:0]                 r_bstart;
    logic [LC_W-1:0]                 r_bend;
    logic [LC_W-1:0]                 r_ln;
    logic [LC_W-1:0]                 r_il;
    logic                            r_drain;
    logic                            r_kind;
    logic signed [plaw_pkg::REM_W-1:0] r_rem;
    logic [plaw_pkg::SUM_W-1:0]      r_sum;
    logic [plaw_pkg::LEN_W-1:0]      r_len;
    logic [plaw_pkg::LEN_W-1:0]      r_r;
    logic signed [CW-1:0]            r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic signed [CW-1:0]            r_px, r_py, r_pz;
    logic [PC_W-1:0]                 r_pseg;
    logic [7:0]                      r_ilink;
    logic [LC_W-1:0]                 r_lseg;
    logic [1:0]                      r_status;
    logic [1:0]                      r_axis;

    logic                            r_out_valid;
    logic [1:0]                      r_o_status;
    logic signed [CW-1:0]            r_o_x, r_o_y, r_o_z;
    logic [10:0]                     r_o_pseg;
    logic [7:0]                      r_o_link;
    logic [10:0]                     r_o_lseg;
    logic [plaw_pkg::ADV_W-1:0]      r_o_adv;

    logic                  w_accept;
    logic                  w_path_we, w_link_we, w_brk_we;
    logic                  w_path_re, w_link_re, w_brk_re;
    logic [PA_W-1:0]       w_path_ra;
    logic [LA_W-1:0]       w_link_ra;
    logic [BA_W-1:0]       w_brk_ra;
    logic [BC_W-1:0]       w_j_next;
    logic [LC_W-1:0]       w_lb, w_la, w_ln;
    logic                  w_link_hit;
    logic                  w_stop;
    logic                  w_out_load;

    plaw_pkg::t_sqrt_req   w_sqrt_req;
    plaw_pkg::t_sqrt_rsp   w_sqrt_rsp;
    plaw_pkg::t_lerp_req   w_lerp_req;
    plaw_pkg::t_lerp_rsp   w_lerp_rsp;

    plaw_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_sqrt_req),
        .o_rsp   (w_sqrt_rsp)
    );

    plaw_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_lerp_req),
        .o_rsp   (w_lerp_rsp)
    );

    assign w_accept   = i_valid && o_ready;
    assign w_path_we  = w_accept && (i_command == plaw_pkg::CMD_PATH_POINT)
                        && (r_pc < PC_W'(PATH_DEPTH));
    assign w_brk_we   = w_accept && (i_command == plaw_pkg::CMD_LINK_START)
                        && (r_bc < BC_W'(LINK_COUNT));
    assign w_link_we  = w_accept && (i_command == plaw_pkg::CMD_LINK_POINT)
                        && (r_bc != '0) && (r_lpc < LC_W'(LINK_POINT_DEPTH));

    assign w_j_next   = r_j + BC_W'(1);
    assign w_lb       = r_bstart + r_il;
    assign w_la       = w_lb - LC_W'(1);
    assign w_ln       = (r_bend > r_bstart) ? (r_bend - r_bstart) : '0;
    // A break is due once the path walk has reached its position.
    assign w_link_hit = r_bvalid && (r_bpos <= r_i);
    assign w_stop     = !r_rem[plaw_pkg::REM_W-1]
                        && ($unsigned(r_rem) <= plaw_pkg::REM_W'(r_len));

    // Memories: one write port used by loads, one registered read port used by queries.
    always_ff @(posedge i_clk) begin
        if (w_path_we) r_path_mem[PA_W'(r_pc)] <= {i_coord_y, i_coord_x};
        if (w_path_re) r_path_rd <= r_path_mem[w_path_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_link_we) begin
            r_lxy_mem[LA_W'(r_lpc)] <= {i_coord_y, i_coord_x};
            r_lz_mem[LA_W'(r_lpc)]  <= i_coord_z;
        end
        if (w_link_re) begin
            r_lxy_rd <= r_lxy_mem[w_link_ra];
            r_lz_rd  <= r_lz_mem[w_link_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_brk_we) r_brk_mem[BA_W'(r_bc)] <= {r_pc, r_lpc};
        if (w_brk_re) r_brk_rd <= r_brk_mem[w_brk_ra];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            plaw_pkg::W_IDLE: begin
                if (w_accept && (i_command == plaw_pkg::CMD_QUERY)) begin
                    n_state = plaw_pkg::W_BRK_FETCH;
                end
            end
            plaw_pkg::W_BRK_FETCH: begin
                n_state = (r_j < r_bc) ? plaw_pkg::W_BRK_POS : plaw_pkg::W_DISPATCH;
            end
            plaw_pkg::W_BRK_POS: begin
                n_state = (w_j_next < r_bc) ? plaw_pkg::W_BRK_END : plaw_pkg::W_DISPATCH;
            end
            plaw_pkg::W_BRK_END: n_state = plaw_pkg::W_DISPATCH;
            plaw_pkg::W_DISPATCH: begin
                if (r_i < r_pc) begin
                    if (w_link_hit) begin
                        n_state = plaw_pkg::W_LINK_TOP;
                    end else if (r_drain) begin
                        n_state = plaw_pkg::W_DISPATCH;
                    end else begin
                        n_state = plaw_pkg::W_SEG_A;
                    end
                end else if (r_bvalid) begin
                    n_state = plaw_pkg::W_LINK_TOP;
                end else begin
                    n_state = plaw_pkg::W_FINISH;
                end
            end
            plaw_pkg::W_LINK_TOP: begin
                if (r_il < r_ln) begin
                    n_state = plaw_pkg::W_SEG_A;
                end else if (r_ln != '0) begin
                    n_state = plaw_pkg::W_LEND_RD;
                end else begin
                    n_state = plaw_pkg::W_BRK_FETCH;
                end
            end
            plaw_pkg::W_SEG_A:  n_state = plaw_pkg::W_SEG_B;
            plaw_pkg::W_SEG_B:  n_state = plaw_pkg::W_SEG_C;
            plaw_pkg::W_SEG_C:  n_state = plaw_pkg::W_LEN_GO;
            plaw_pkg::W_LEN_GO: n_state = plaw_pkg::W_LEN_WAIT;
            plaw_pkg::W_LEN_WAIT: begin
                if (w_sqrt_rsp.done) n_state = plaw_pkg::W_CHECK;
            end
            plaw_pkg::W_CHECK: begin
                if (w_stop) begin
                    n_state = plaw_pkg::W_LERP_GO;
                end else begin
                    n_state = r_kind ? plaw_pkg::W_LINK_TOP : plaw_pkg::W_DISPATCH;
                end
            end
            plaw_pkg::W_LERP_GO: n_state = plaw_pkg::W_LERP_WAIT;
            plaw_pkg::W_LERP_WAIT: begin
                if (w_lerp_rsp.done) begin
                    n_state = (r_axis == 2'd2) ? plaw_pkg::W_FINISH : plaw_pkg::W_LERP_GO;
                end
            end
            plaw_pkg::W_LEND_RD:  n_state = plaw_pkg::W_LEND_CAP;
            plaw_pkg::W_LEND_CAP: n_state = plaw_pkg::W_BRK_FETCH;
            plaw_pkg::W_FINISH: begin
                if (w_out_load) n_state = plaw_pkg::W_IDLE;
            end
            default: n_state = plaw_pkg::W_IDLE;
        endcase
    end

    // State outputs: handshake, memory read ports and unit requests.
    always_comb begin
        o_ready    = (r_state == plaw_pkg::W_IDLE);
        w_out_load = (r_state == plaw_pkg::W_FINISH) && (!r_out_valid || i_ready);
        w_path_re  = 1'b0;
        w_path_ra  = PA_W'(r_i);
        w_link_re  = 1'b0;
        w_link_ra  = LA_W'(w_lb);
        w_brk_re   = 1'b0;
        w_brk_ra   = BA_W'(r_j);
        case (r_state)
            plaw_pkg::W_BRK_FETCH: begin
                w_brk_re = (r_j < r_bc);
            end
            plaw_pkg::W_BRK_POS: begin
                w_brk_re = (w_j_next < r_bc);
                w_brk_ra = BA_W'(w_j_next);
            end
            plaw_pkg::W_SEG_A: begin
                w_path_re = !r_kind;
                w_path_ra = PA_W'(r_i - PC_W'(1));
                w_link_re = r_kind;
                w_link_ra = LA_W'(w_la);
            end
            plaw_pkg::W_SEG_B: begin
                w_path_re = !r_kind;
                w_link_re = r_kind;
            end
            plaw_pkg::W_LEND_RD: begin
                w_link_re = 1'b1;
                w_link_ra = LA_W'(r_bend - LC_W'(1));
            end
            default: begin
                w_path_re = 1'b0;
            end
        endcase

        w_sqrt_req.start = (r_state == plaw_pkg::W_LEN_GO);
        w_sqrt_req.dx    = {r_bx[CW-1], r_bx} - {r_ax[CW-1], r_ax};
        w_sqrt_req.dy    = {r_by[CW-1], r_by} - {r_ay[CW-1], r_ay};
        w_sqrt_req.dz    = {r_bz[CW-1], r_bz} - {r_az[CW-1], r_az};

        w_lerp_req.start = (r_state == plaw_pkg::W_LERP_GO);
        w_lerp_req.num   = r_r;
        w_lerp_req.den   = r_len;
        case (r_axis)
            2'd0: begin
                w_lerp_req.p0 = r_ax;
                w_lerp_req.p1 = r_bx;
            end
            2'd1: begin
                w_lerp_req.p0 = r_ay;
                w_lerp_req.p1 = r_by;
            end
            default: begin
                w_lerp_req.p0 = r_az;
                w_lerp_req.p1 = r_bz;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plaw_pkg::W_IDLE;
            r_pc    <= '0;
            r_lpc   <= '0;
            r_bc    <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept && (i_command == plaw_pkg::CMD_CLEAR)) begin
                r_pc  <= '0;
                r_lpc <= '0;
                r_bc  <= '0;
            end
            if (w_path_we) r_pc  <= r_pc + PC_W'(1);
            if (w_link_we) r_lpc <= r_lpc + LC_W'(1);
            if (w_brk_we)  r_bc  <= r_bc + BC_W'(1);
        end
    end

    // Walk datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            plaw_pkg::W_IDLE: begin
                r_i      <= PC_W'(1);
                r_j      <= '0;
                r_drain  <= 1'b0;
                r_rem    <= plaw_pkg::REM_W'(i_distance);
                r_sum    <= '0;
                r_px     <= '0;
                r_py     <= '0;
                r_pz     <= '0;
                r_pseg   <= '0;
                r_ilink  <= '1;
                r_lseg   <= '0;
                r_status <= plaw_pkg::ST_PAST;
            end
            plaw_pkg::W_BRK_FETCH: begin
                r_bvalid <= (r_j < r_bc);
            end
            plaw_pkg::W_BRK_POS: begin
                r_bpos   <= r_brk_rd[BRK_W-1:LC_W];
                r_bstart <= r_brk_rd[LC_W-1:0];
                if (!(w_j_next < r_bc)) r_bend <= r_lpc;
            end
            plaw_pkg::W_BRK_END: begin
                r_bend <= r_brk_rd[LC_W-1:0];
            end
            plaw_pkg::W_DISPATCH: begin
                if ((r_i < r_pc) ? w_link_hit : r_bvalid) begin
                    r_drain <= (r_i < r_pc);
                    r_ilink <= 8'(r_j);
                    r_il    <= LC_W'(1);
                    r_ln    <= w_ln;
                    r_kind  <= 1'b1;
                end else if ((r_i < r_pc) && r_drain) begin
                    // The path segment at a drained break is replaced by its links.
                    r_drain <= 1'b0;
                    r_i     <= r_i + PC_W'(1);
                end else begin
                    r_kind  <= 1'b0;
                end
            end
            plaw_pkg::W_LINK_TOP: begin
                if (!(r_il < r_ln)) begin
                    r_lseg <= r_ln;
                    if (r_ln == '0) r_j <= w_j_next;
                end
            end
            plaw_pkg::W_SEG_B: begin
                if (r_kind) begin
                    r_ax <= r_lxy_rd[CW-1:0];
                    r_ay <= r_lxy_rd[2*CW-1:CW];
                    r_az <= r_lz_rd;
                end else begin
                    r_ax <= r_path_rd[CW-1:0];
                    r_ay <= r_path_rd[2*CW-1:CW];
                    r_az <= '0;
                end
            end
            plaw_pkg::W_SEG_C: begin
                if (r_kind) begin
                    r_bx <= r_lxy_rd[CW-1:0];
                    r_by <= r_lxy_rd[2*CW-1:CW];
                    r_bz <= r_lz_rd;
                end else begin
                    r_bx <= r_path_rd[CW-1:0];
                    r_by <= r_path_rd[2*CW-1:CW];
                    r_bz <= '0;
                end
            end
            plaw_pkg::W_LEN_WAIT: begin
                if (w_sqrt_rsp.done) r_len <= w_sqrt_rsp.len;
            end
            plaw_pkg::W_CHECK: begin
                if (w_stop) begin
                    r_sum  <= r_sum + plaw_pkg::SUM_W'($unsigned(r_rem));
                    r_r    <= plaw_pkg::LEN_W'($unsigned(r_rem));
                    r_axis <= 2'd0;
                    if (r_kind) begin
                        r_lseg   <= r_il;
                        r_status <= plaw_pkg::ST_LINK;
                    end else begin
                        r_ilink  <= 8'(r_j);
                        r_lseg   <= '0;
                        r_pseg   <= r_i;
                        r_status <= plaw_pkg::ST_PATH;
                    end
                end else begin
                    r_sum <= r_sum + plaw_pkg::SUM_W'(r_len);
                    r_rem <= r_rem - plaw_pkg::REM_W'(r_len);
                    r_px  <= r_bx;
                    r_py  <= r_by;
                    r_pz  <= r_bz;
                    if (r_kind) begin
                        r_lseg <= r_il;
                        r_il   <= r_il + LC_W'(1);
                    end else begin
                        r_pseg <= r_i;
                        r_i    <= r_i + PC_W'(1);
                    end
                end
            end
            plaw_pkg::W_LERP_WAIT: begin
                if (w_lerp_rsp.done) begin
                    case (r_axis)
                        2'd0:    r_px <= w_lerp_rsp.point;
                        2'd1:    r_py <= w_lerp_rsp.point;
                        default: r_pz <= w_lerp_rsp.point;
                    endcase
                    r_axis <= r_axis + 2'd1;
                end
            end
            plaw_pkg::W_LEND_CAP: begin
                r_px <= r_lxy_rd[CW-1:0];
                r_py <= r_lxy_rd[2*CW-1:CW];
                r_pz <= r_lz_rd;
                r_j  <= w_j_next;
            end
            default: begin
                r_axis <= r_axis;
            end
        endcase
    end

    // Output register: parts the walk from the consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_status <= r_status;
            r_o_x      <= r_px;
            r_o_y      <= r_py;
            r_o_z      <= r_pz;
            r_o_pseg   <= 11'(r_pseg);
            r_o_link   <= r_ilink;
            r_o_lseg   <= 11'(r_lseg);
            // The advanced length saturates at the largest Q32.16 value.
            r_o_adv    <= (r_sum > plaw_pkg::SUM_W'({plaw_pkg::ADV_W{1'b1}}))
                          ? {plaw_pkg::ADV_W{1'b1}} : r_sum[plaw_pkg::ADV_W-1:0];
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_o_status;
    assign o_point_x         = r_o_x;
    assign o_point_y         = r_o_y;
    assign o_point_z         = r_o_z;
    assign o_path_segment    = r_o_pseg;
    assign o_link_number     = r_o_link;
    assign o_link_segment    = r_o_lseg;
    assign o_advanced_length = r_o_adv;

endmodule

FILE: rtl/core/plaw_checker.sv
`timescale 1ns / 1ps
// Port checker for the arc length locator and its bind to the top level.
module plaw_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic [2:0]         i_command,
    input logic               o_valid,
    input logic               i_ready,
    input logic [1:0]         o_status,
    input logic signed [31:0] o_point_x,
    input logic signed [31:0] o_point_y,
    input logic signed [31:0] o_point_z,
    input logic [10:0]        o_path_segment,
    input logic signed [7:0]  o_link_number,
    input logic [10:0]        o_link_segment,
    input logic [46:0]        o_advanced_length
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid
        && $stable({o_status, o_point_x, o_point_y, o_point_z, o_path_segment,
                    o_link_number, o_link_segment, o_advanced_length}))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("block not idle after reset");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_command == plaw_pkg::CMD_QUERY) |=> !o_ready)
        else $error("new command taken while a query is walking");

    a_path_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == plaw_pkg::ST_PATH) |-> (o_point_z == '0)
        && (o_link_segment == '0))
        else $error("path stop reports link data");

endmodule

bind polyline_arc_length_locator plaw_checker u_plaw_checker (.*);

FILE: tb/sv/tb_polyline_arc_length_locator.sv
`timescale 1ns / 1ps
// Self-checking testbench of the toolpath arc length locator.
module tb_polyline_arc_length_locator;

    // Command codes that the block ignores.
    localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI  = 3'd7;
    localparam int P_DEPTH = 1024;
    localparam int L_DEPTH = 1024;
    localparam int B_DEPTH = 64;
    localparam longint unsigned ADV_SAT = 64'h7FFF_FFFF_FFFF;

    typedef struct {
        logic [2:0]         cmd;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [47:0] reach;
    } t_cmd_item;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [10:0]        pseg;
        logic signed [7:0]  link;
        logic [10:0]        lseg;
        logic [46:0]        adv;
    } t_fix;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [2:0]         i_command = plaw_pkg::CMD_CLEAR;
    logic signed [31:0] i_coord_x = '0;
    logic signed [31:0] i_coord_y = '0;
    logic signed [31:0] i_coord_z = '0;
    logic signed [47:0] i_distance = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_point_x;
    logic signed [31:0] o_point_y;
    logic signed [31:0] o_point_z;
    logic [10:0]        o_path_segment;
    logic signed [7:0]  o_link_number;
    logic [10:0]        o_link_segment;
    logic [46:0]        o_advanced_length;

    polyline_arc_length_locator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_command(i_command), .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .i_coord_z(i_coord_z), .i_distance(i_distance),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_point_x(o_point_x), .o_point_y(o_point_y),
        .o_point_z(o_point_z), .o_path_segment(o_path_segment),
        .o_link_number(o_link_number), .o_link_segment(o_link_segment),
        .o_advanced_length(o_advanced_length)
    );

    always #10 i_clk = ~i_clk;

    // Stimulus and expectations.
    t_cmd_item pending_cmds[$];
    t_fix      expected_fixes[$];
    int        errors = 0;
    int        n_queries = 0;
    int        n_on_path = 0;
    int        n_on_link = 0;
    int        n_past_end = 0;
    int        sender_idle_pct = 0;
    int        receiver_stall_pct = 0;
    int        hold_request = 0;
    bit        stim_enable = 0;

    // Shadow copy of the block's stores and fill counts.
    logic signed [31:0] path_x[P_DEPTH];
    logic signed [31:0] path_y[P_DEPTH];
    logic signed [31:0] lnk_x[L_DEPTH];
    logic signed [31:0] lnk_y[L_DEPTH];
    logic signed [31:0] lnk_z[L_DEPTH];
    int unsigned        brk_pos[B_DEPTH];
    int unsigned        brk_first[B_DEPTH];
    int unsigned        n_path = 0;
    int unsigned        n_lpts = 0;
    int unsigned        n_brk = 0;

    // State of the walk in progress.
    longint             w_rem;
    longint unsigned    w_sum;
    longint             w_px, w_py, w_pz;
    int unsigned        w_pseg, w_lseg;
    int                 w_ilink;
    logic [1:0]         w_status;

    function automatic longint unsigned magnitude(longint d);
        return d < 0 ? longint'(-d) : d;
    endfunction

    // Segment length: square root, rounded down, of the exact sum of squares.
    function automatic longint unsigned segment_length(longint dx, longint dy, longint dz);
        logic [127:0]    acc;
        longint unsigned r;
        longint unsigned c;
        acc = 128'(magnitude(dx)) * 128'(magnitude(dx)) + 128'(magnitude(dy)) * 128'(magnitude(dy))
            + 128'(magnitude(dz)) * 128'(magnitude(dz));
        r = 0;
        for (int b = 34; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= acc) r = c;
        end
        return r;
    endfunction

    // Linear interpolation with the quotient magnitude rounded toward p0.
    function automatic longint interpolate(longint p0, longint p1, longint unsigned num,
                                           longint unsigned den);
        longint       d;
        logic [127:0] q;
        if (den == 0) return p0;
        d = p1 - p0;
        q = (128'(magnitude(d)) * 128'(num)) / 128'(den);
        return d < 0 ? p0 - longint'(q[63:0]) : p0 + longint'(q[63:0]);
    endfunction

    function automatic bit fits_here(longint unsigned len);
        return w_rem >= 0 && longint'(w_rem) <= longint'(len);
    endfunction

    function automatic bit walk_link(int unsigned j);
        int unsigned     s, e, n, a, b;
        longint unsigned len;
        s = brk_first[j];
        e = (j + 1 < n_brk) ? brk_first[j + 1] : n_lpts;
        n = e > s ? e - s : 0;
        w_ilink = j;
        for (int unsigned il = 1; il < n; il++) begin
            a = s + il - 1;
            b = s + il;
            len = segment_length(longint'(lnk_x[b]) - lnk_x[a], longint'(lnk_y[b]) - lnk_y[a],
                                 longint'(lnk_z[b]) - lnk_z[a]);
            if (fits_here(len)) begin
                w_sum += w_rem;
                w_lseg = il;
                w_px = interpolate(lnk_x[a], lnk_x[b], w_rem, len);
                w_py = interpolate(lnk_y[a], lnk_y[b], w_rem, len);
                w_pz = interpolate(lnk_z[a], lnk_z[b], w_rem, len);
                w_status = plaw_pkg::ST_LINK;
                return 1;
            end
            w_sum += len;
            w_rem -= longint'(len);
            w_px = lnk_x[b]; w_py = lnk_y[b]; w_pz = lnk_z[b];
            w_lseg = il;
        end
        w_lseg = n;
        if (n > 0) begin
            w_px = lnk_x[e - 1]; w_py = lnk_y[e - 1]; w_pz = lnk_z[e - 1];
        end
        return 0;
    endfunction

    function automatic t_fix locate_point(logic signed [47:0] reach);
        int unsigned     j;
        longint unsigned len;
        t_fix            f;
        bit              done;
        w_rem = longint'(reach);
        w_sum = 0; w_px = 0; w_py = 0; w_pz = 0;
        w_pseg = 0; w_lseg = 0; w_ilink = -1; w_status = plaw_pkg::ST_PAST;
        j = 0;
        done = 0;
        for (int unsigned i = 1; i < n_path && !done; i++) begin
            if (j < n_brk && brk_pos[j] <= i) begin
                // Links attached here replace the path segment ending at point i.
                while (!done && j < n_brk && brk_pos[j] <= i) begin
                    if (walk_link(j)) done = 1;
                    else j++;
                end
            end else begin
                len = segment_length(longint'(path_x[i]) - path_x[i - 1],
                                     longint'(path_y[i]) - path_y[i - 1], 0);
                if (fits_here(len)) begin
                    w_sum += w_rem;
                    w_ilink = j;
                    w_lseg = 0;
                    w_pseg = i;
                    w_px = interpolate(path_x[i - 1], path_x[i], w_rem, len);
                    w_py = interpolate(path_y[i - 1], path_y[i], w_rem, len);
                    w_pz = 0;
                    w_status = plaw_pkg::ST_PATH;
                    done = 1;
                end else begin
                    w_sum += len;
                    w_rem -= longint'(len);
                    w_px = path_x[i]; w_py = path_y[i]; w_pz = 0;
                    w_pseg = i;
                end
            end
        end
        // Trailing links and any break left over are walked after the path.
        while (!done && j < n_brk) begin
            if (walk_link(j)) done = 1;
            else j++;
        end
        if (!done) w_status = plaw_pkg::ST_PAST;
        f.status = w_status;
        f.px = w_px[31:0];
        f.py = w_py[31:0];
        f.pz = w_pz[31:0];
        f.pseg = w_pseg[10:0];
        f.link = w_ilink[7:0];
        f.lseg = w_lseg[10:0];
        f.adv = w_sum > ADV_SAT ? ADV_SAT[46:0] : w_sum[46:0];
        return f;
    endfunction

    // Applies one accepted command to the shadow state.
    task automatic apply_command(t_cmd_item it);
        case (it.cmd)
            plaw_pkg::CMD_CLEAR: begin
                n_path = 0; n_lpts = 0; n_brk = 0;
            end
            plaw_pkg::CMD_PATH_POINT: begin
                if (n_path < P_DEPTH) begin
                    path_x[n_path] = it.x; path_y[n_path] = it.y;
                    n_path++;
                end
            end
            plaw_pkg::CMD_LINK_START: begin
                if (n_brk < B_DEPTH) begin
                    brk_pos[n_brk] = n_path;
                    brk_first[n_brk] = n_lpts;
                    n_brk++;
                end
            end
            plaw_pkg::CMD_LINK_POINT: begin
                if (n_brk > 0 && n_lpts < L_DEPTH) begin
                    lnk_x[n_lpts] = it.x; lnk_y[n_lpts] = it.y; lnk_z[n_lpts] = it.z;
                    n_lpts++;
                end
            end
            plaw_pkg::CMD_QUERY: begin
                expected_fixes = {expected_fixes, locate_point(it.reach)};
            end
            default: ;
        endcase
    endtask

    // Driver: a new item can go out at the falling edge after the previous transfer; the sender idles at random.
    bit took = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            apply_command('{i_command, i_coord_x, i_coord_y, i_coord_z, i_distance});
            took = 1;
        end
    end

    always @(negedge i_clk) begin
        t_cmd_item it;
        if (!i_valid || took) begin
            took = 0;
            if (stim_enable && pending_cmds.size() > 0 &&
                $urandom_range(99) >= sender_idle_pct) begin
                it = pending_cmds.pop_front();
                i_command <= it.cmd;
                i_coord_x <= it.x;
                i_coord_y <= it.y;
                i_coord_z <= it.z;
                i_distance <= it.reach;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    int hold_left = 0;
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Monitor: each result transfer is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_fix e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_fixes.size() == 0) begin
                $display("%0t: result transfer with no query waiting", $time);
                errors++;
            end else begin
                e = expected_fixes.pop_front();
                n_queries++;
                if (e.status == plaw_pkg::ST_PATH) n_on_path++;
                else if (e.status == plaw_pkg::ST_LINK) n_on_link++;
                else n_past_end++;
                check_field("status", e.status, o_status);
                check_field("point_x", e.px, o_point_x);
                check_field("point_y", e.py, o_point_y);
                check_field("point_z", e.pz, o_point_z);
                check_field("path_segment", e.pseg, o_path_segment);
                check_field("link_number", e.link, o_link_number);
                check_field("link_segment", e.lseg, o_link_segment);
                check_field("advanced_length", e.adv, o_advanced_length);
            end
        end
    end

    task automatic push_cmd(logic [2:0] c, logic signed [31:0] x = 0, logic signed [31:0] y = 0,
                            logic signed [31:0] z = 0, logic signed [47:0] d = 0);
        t_cmd_item it;
        it.cmd = c; it.x = x; it.y = y; it.z = z; it.reach = d;
        pending_cmds = {pending_cmds, it};
    endtask

    // Waits until every item has gone out and every expected result has come.
    task automatic wait_drained();
        while (pending_cmds.size() > 0 || i_valid || expected_fixes.size() > 0)
            @(posedge i_clk);
    endtask

    // Next coordinate: mostly a modest step from the previous one, sometimes a repeat
    // (zero-length segment) or a jump anywhere in the full range.
    function automatic logic signed [31:0] next_coord(logic signed [31:0] prev);
        case ($urandom_range(9))
            0: return prev;
            1: return $urandom;
            2, 3, 4: return prev + $signed($urandom_range(0, 2097152)) - 1048576;
            default: return prev + $signed($urandom_range(0, 67108864)) - 33554432;
        endcase
    endfunction

    function automatic logic signed [47:0] rand_distance();
        logic [47:0] v;
        v = 48'({$urandom, $urandom});
        case ($urandom_range(9))
            0: return {1'b1, v[46:0]};
            1: return 0;
            2: return v;
            default: return v & ((48'd1 << $urandom_range(0, 40)) - 1);
        endcase
    endfunction

    // Random scenes: a cleared toolpath with links, then queries, with some noise.
    task automatic random_scenes(int target);
        int                 pushed;
        int                 npts;
        logic signed [31:0] x, y, z;
        pushed = 0;
        while (pushed < target) begin
            push_cmd(plaw_pkg::CMD_CLEAR);
            pushed++;
            x = $urandom; y = $urandom; z = $urandom;
            if ($urandom_range(9) == 0) begin
                push_cmd(plaw_pkg::CMD_LINK_POINT, x, y, z);
                pushed++;
            end
            npts = $urandom_range(0, 12);
            for (int k = 0; k < npts; k++) begin
                if ($urandom_range(4) == 0) begin
                    push_cmd(plaw_pkg::CMD_LINK_START);
                    pushed++;
                    for (int m = $urandom_range(0, 4); m > 0; m--) begin
                        x = next_coord(x); y = next_coord(y); z = next_coord(z);
                        push_cmd(plaw_pkg::CMD_LINK_POINT, x, y, z);
                        pushed++;
                    end
                end
                x = next_coord(x); y = next_coord(y);
                push_cmd(plaw_pkg::CMD_PATH_POINT, x, y, $urandom);
                pushed++;
                if ($urandom_range(19) == 0)
                    push_cmd(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), $urandom,
                             $urandom, $urandom, 48'({$urandom, $urandom}));
            end
            if ($urandom_range(1) == 0) begin
                push_cmd(plaw_pkg::CMD_LINK_START);
                pushed++;
                for (int m = $urandom_range(0, 4); m > 0; m--) begin
                    x = next_coord(x); y = next_coord(y); z = next_coord(z);
                    push_cmd(plaw_pkg::CMD_LINK_POINT, x, y, z);
                    pushed++;
                end
            end
            for (int q = $urandom_range(1, 4); q > 0; q--) begin
                push_cmd(plaw_pkg::CMD_QUERY, $urandom, $urandom, $urandom, rand_distance());
                pushed++;
            end
        end
    endtask

    initial begin
        #80_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        stim_enable = 1;

        // Directed: empty store, extreme coordinates, zero-length segment, a link point
        // before any link, leading and trailing links, extreme distances, spare codes.
        push_cmd(plaw_pkg::CMD_QUERY, 0, 0, 0, -48'sd1);
        push_cmd(plaw_pkg::CMD_QUERY, 0, 0, 0, 0);
        push_cmd(plaw_pkg::CMD_LINK_POINT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_cmd(plaw_pkg::CMD_LINK_START);
        push_cmd(plaw_pkg::CMD_LINK_POINT, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        push_cmd(plaw_pkg::CMD_LINK_POINT, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_cmd(plaw_pkg::CMD_PATH_POINT, 32'sh8000_0000, 32'sh7FFF_FFFF);
        push_cmd(plaw_pkg::CMD_PATH_POINT, 32'sh7FFF_FFFF, 32'sh8000_0000);
        push_cmd(plaw_pkg::CMD_PATH_POINT, 32'sh7FFF_FFFF, 32'sh8000_0000);
        push_cmd(plaw_pkg::CMD_PATH_POINT, 32'sh0001_0000, 32'sh0002_0000);
        push_cmd(plaw_pkg::CMD_LINK_START);
        push_cmd(plaw_pkg::CMD_LINK_POINT, 0, 0, 32'sh0003_0000);
        push_cmd(plaw_pkg::CMD_LINK_POINT, 32'sh0004_0000, 0, 32'sh0003_0000);
        push_cmd(plaw_pkg::CMD_QUERY, 0, 0, 0, 0);
        push_cmd(plaw_pkg::CMD_QUERY, 0, 0, 0, -48'sd1);
        push_cmd(plaw_pkg::CMD_QUERY, 0, 0, 0, 48'sh7FFF_FFFF_FFFF);
        push_cmd(plaw_pkg::CMD_QUERY, 0, 0, 0, 48'sh8000_0000_0000);
        push_cmd(plaw_pkg::CMD_QUERY, 0, 0, 0, 48'sh0000_5A82_7999);
        push_cmd(plaw_pkg::CMD_QUERY, 0, 0, 0, 48'sh0001_6A09_E667);
        push_cmd(CMD_SPARE_LO, -1, -1, -1, -48'sd1);
        push_cmd(CMD_SPARE_HI, -1, -1, -1, -48'sd1);
        push_cmd(CMD_SPARE_MID, 0, 0, 0, 0);
        push_cmd(plaw_pkg::CMD_QUERY, 0, 0, 0, 48'sd65536);
        wait_drained();

        // Full stores: the extra path point, link start and link point are dropped.
        push_cmd(plaw_pkg::CMD_CLEAR);
        for (int k = 0; k <= P_DEPTH; k++)
            push_cmd(plaw_pkg::CMD_PATH_POINT, k * 32'sh0000_8000, -k * 32'sh0000_4000);
        for (int k = 0; k <= B_DEPTH; k++) push_cmd(plaw_pkg::CMD_LINK_START);
        push_cmd(plaw_pkg::CMD_QUERY, 0, 0, 0, 48'sd3_000_000);
        push_cmd(plaw_pkg::CMD_QUERY, 0, 0, 0, -48'sd1);
        push_cmd(plaw_pkg::CMD_CLEAR);
        push_cmd(plaw_pkg::CMD_PATH_POINT, 0, 0);
        push_cmd(plaw_pkg::CMD_LINK_START);
        for (int k = 0; k <= L_DEPTH; k++)
            push_cmd(plaw_pkg::CMD_LINK_POINT, k * 32'sh0000_1000, k * 32'sh0000_2000,
                     -k * 32'sh0000_3000);
        push_cmd(plaw_pkg::CMD_PATH_POINT, 32'sh0010_0000, 0);
        push_cmd(plaw_pkg::CMD_QUERY, 0, 0, 0, 48'sd500_000);
        push_cmd(plaw_pkg::CMD_QUERY, 0, 0, 0, -48'sd5);
        wait_drained();

        // Random part under four handshake regimes.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 55; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 55; end
                default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
            endcase
            random_scenes(220);
            wait_drained();
        end

        // Back-pressure: the receiver holds off while queries keep coming, so the block
        // fills its output register and stalls further transfers.
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        random_scenes(60);
        for (int q = 0; q < 6; q++) push_cmd(plaw_pkg::CMD_QUERY, 0, 0, 0, rand_distance());
        @(posedge i_clk);
        hold_request = 4000;
        wait_drained();

        // Nothing is in flight; allow a short settling time for stray results.
        repeat (400) @(posedge i_clk);
        $display("Checked %0d queries: %0d stopped on the path, %0d on a link, %0d past the end.",
                 n_queries, n_on_path, n_on_link, n_past_end);
        $display("Covered full stores, extreme coordinates and distances, and four stall regimes.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: polyline_arc_length_locator.f
rtl/core/plaw_pkg.sv
rtl/core/plaw_sqrt.sv
rtl/core/plaw_lerp.sv
rtl/core/polyline_arc_length_locator.sv
rtl/core/plaw_checker.sv
tb/sv/tb_polyline_arc_length_locator.sv
